/* hdl/lsc_pkg.sv */
// ---------------------------------------------------------------------------
// lsc_pkg
// Shared types, constants and tables of the lookahead steering controller.
// ---------------------------------------------------------------------------
package lsc_pkg;

    localparam int MAX_WAYPOINTS = 256;
    localparam int CORDIC_STEPS  = 16;

    localparam int CW  = 24;              // coordinate width
    localparam int DW  = CW + 1;          // coordinate difference width
    localparam int XW  = 44;              // cordic x/y width
    localparam int ZW  = 29;              // cordic angle width, rad * 2^24
    localparam int HW  = 15;              // heading width
    localparam int BW  = ZW - 12;         // bearing width, rad * 4096
    localparam int EW  = BW + 1;          // error width
    localparam int GW  = 12;              // gain width
    localparam int PW  = EW + GW + 1;     // product width
    localparam int AVW = 23;              // angular velocity width

    localparam logic signed [ZW-1:0] PI_Q24 = ZW'(52707179);
    localparam logic signed [AVW-1:0] ANG_MAX = 23'sh3FFFFF;
    localparam logic signed [AVW-1:0] ANG_MIN = 23'sh400000;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef enum logic [1:0] {
        CFG_LOOKAHEAD = 2'd0,
        CFG_SPEED     = 2'd1,
        CFG_GAIN      = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CSTART,
        S_CWAIT,
        S_ERR,
        S_MUL,
        S_RES
    } t_state;

    typedef struct packed {
        logic                 start;
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
    } t_cordic_req;

    typedef struct packed {
        logic                 done;
        logic signed [ZW-1:0] z;
    } t_cordic_rsp;

    function automatic logic signed [ZW-1:0] atan_q24(input logic [4:0] i);
        logic signed [ZW-1:0] v;
        case (i)
            5'd0:  v = ZW'(13176795);
            5'd1:  v = ZW'(7778716);
            5'd2:  v = ZW'(4110060);
            5'd3:  v = ZW'(2086331);
            5'd4:  v = ZW'(1047214);
            5'd5:  v = ZW'(524117);
            5'd6:  v = ZW'(262123);
            5'd7:  v = ZW'(131069);
            5'd8:  v = ZW'(65536);
            5'd9:  v = ZW'(32768);
            5'd10: v = ZW'(16384);
            5'd11: v = ZW'(8192);
            5'd12: v = ZW'(4096);
            5'd13: v = ZW'(2048);
            5'd14: v = ZW'(1024);
            5'd15: v = ZW'(512);
            5'd16: v = ZW'(256);
            5'd17: v = ZW'(128);
            5'd18: v = ZW'(64);
            5'd19: v = ZW'(32);
            5'd20: v = ZW'(16);
            5'd21: v = ZW'(8);
            5'd22: v = ZW'(4);
            5'd23: v = ZW'(2);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

/* hdl/lsc_in_if.sv */
// ---------------------------------------------------------------------------
// lsc_in_if
// Input word channel: waypoint loads and control ticks.
// ---------------------------------------------------------------------------
interface lsc_in_if;
    logic                     valid;
    logic                     ready;
    logic                     command;
    logic signed [23:0]       point_x;
    logic signed [23:0]       point_y;
    logic                     path_end;
    logic signed [14:0]       robot_heading;

    modport source (output valid, command, point_x, point_y, path_end, robot_heading,
                    input ready);
    modport sink   (input valid, command, point_x, point_y, path_end, robot_heading,
                    output ready);
endinterface

/* hdl/lsc_out_if.sv */
// ---------------------------------------------------------------------------
// lsc_out_if
// Output word channel: velocity commands.
// ---------------------------------------------------------------------------
interface lsc_out_if;
    logic               valid;
    logic               ready;
    logic [15:0]        linear_velocity;
    logic signed [22:0] angular_velocity;
    logic               target_found;

    modport source (output valid, linear_velocity, angular_velocity, target_found,
                    input ready);
    modport sink   (input valid, linear_velocity, angular_velocity, target_found,
                    output ready);
endinterface

/* hdl/lsc_ram.sv */
// ---------------------------------------------------------------------------
// lsc_ram
// Generic single-write, single-read synchronous RAM, registered read.
// ---------------------------------------------------------------------------
module lsc_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* hdl/lsc_cordic.sv */
// ---------------------------------------------------------------------------
// lsc_cordic
// Iterative vectoring CORDIC atan2, one micro-rotation per cycle.
// ---------------------------------------------------------------------------
module lsc_cordic #(
    parameter int STEPS = lsc_pkg::CORDIC_STEPS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lsc_pkg::t_cordic_req i_req,
    output lsc_pkg::t_cordic_rsp o_rsp
);
    localparam int XW = lsc_pkg::XW;
    localparam int ZW = lsc_pkg::ZW;
    localparam int DW = lsc_pkg::DW;
    localparam int IW = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic signed [XW-1:0] r_x, r_y;
    logic signed [ZW-1:0] r_z;
    logic [IW-1:0]        r_i;
    logic                 r_busy, r_done, r_zero;

    logic signed [XW-1:0] init_x, init_y, ext_x, ext_y, xs, ys, step_x, step_y;
    logic signed [ZW-1:0] init_z, step_z, atan_v;
    logic                 last;

    always_comb begin
        ext_x = XW'({i_req.dx, 16'b0});
        ext_y = XW'({i_req.dy, 16'b0});
        ext_x = {{(XW-DW-16){i_req.dx[DW-1]}}, i_req.dx, 16'b0};
        ext_y = {{(XW-DW-16){i_req.dy[DW-1]}}, i_req.dy, 16'b0};
        if (i_req.dx[DW-1]) begin
            init_x = -ext_x;
            init_y = -ext_y;
            init_z = i_req.dy[DW-1] ? -lsc_pkg::PI_Q24 : lsc_pkg::PI_Q24;
        end else begin
            init_x = ext_x;
            init_y = ext_y;
            init_z = '0;
        end

        xs     = r_x >>> r_i;
        ys     = r_y >>> r_i;
        atan_v = lsc_pkg::atan_q24(5'(r_i));
        if (!r_y[XW-1]) begin
            step_x = r_x + ys;
            step_y = r_y - xs;
            step_z = r_z + atan_v;
        end else begin
            step_x = r_x - ys;
            step_y = r_y + xs;
            step_z = r_z - atan_v;
        end
        last = (r_i == IW'(STEPS - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && last;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && last) begin
                r_busy <= 1'b0;
            end
        end
        if (i_req.start) begin
            r_x    <= init_x;
            r_y    <= init_y;
            r_z    <= init_z;
            r_i    <= '0;
            r_zero <= (i_req.dx == '0) && (i_req.dy == '0);
        end else if (r_busy) begin
            r_x <= step_x;
            r_y <= step_y;
            r_z <= step_z;
            r_i <= r_i + IW'(1);
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.z    = r_zero ? '0 : r_z;
endmodule

/* hdl/lookahead_steering_controller_unit.sv */
// ---------------------------------------------------------------------------
// lookahead_steering_controller_unit
// Path tracker: waypoint store, lookahead scan, CORDIC bearing, turn command.
// ---------------------------------------------------------------------------
//  channel   dir  word
//  i_in      in   command, point_x, point_y, path_end, robot_heading
//  o_out     out  linear_velocity, angular_velocity, target_found
//  i_cfg_*   in   register index, data (lookahead, speed, gain)
//
//  Load: written straight into the waypoint RAM.
//  Tick: scan streams one waypoint per cycle through a RAM read, difference and
//  square pipeline until the first hit or the end of the path, then the CORDIC
//  computes the bearing and the turn command is formed.
//  Reset clears path length, load index and valid flags; the RAM is not cleared.
//  A finished word waits in the output register; the next word is taken meanwhile.
// ---------------------------------------------------------------------------
module lookahead_steering_controller_unit #(
    parameter int MAX_WAYPOINTS = lsc_pkg::MAX_WAYPOINTS,
    parameter int CORDIC_STEPS  = lsc_pkg::CORDIC_STEPS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lsc_in_if.sink      i_in,
    lsc_out_if.source   o_out,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    localparam int AW  = $clog2(MAX_WAYPOINTS);
    localparam int LW  = AW + 1;
    localparam int CW  = lsc_pkg::CW;
    localparam int DW  = lsc_pkg::DW;
    localparam int SQW = 2 * DW;
    localparam int BW  = lsc_pkg::BW;
    localparam int EW  = lsc_pkg::EW;
    localparam int PW  = lsc_pkg::PW;
    localparam int AVW = lsc_pkg::AVW;
    localparam int HW  = lsc_pkg::HW;

    lsc_pkg::t_state r_state, n_state;

    logic [15:0] r_look, r_speed;
    logic [11:0] r_gain;
    logic [LW-1:0] r_len, r_load_idx, r_k;
    logic [31:0] r_la2;
    logic signed [CW-1:0] r_px, r_py, r_tx, r_ty, r_wx2, r_wy2, r_wx3, r_wy3;
    logic signed [HW-1:0] r_head;
    logic r_v1, r_v2, r_v3, r_found;
    logic signed [DW-1:0] r_dx, r_dy;
    logic signed [SQW-1:0] r_sqx, r_sqy;
    logic signed [BW-1:0] r_bear;
    logic signed [EW-1:0] r_err;
    logic signed [PW-1:0] r_prod;

    logic r_ovalid, r_ofound;
    logic [15:0] r_olin;
    logic signed [AVW-1:0] r_oang;

    logic in_acc, is_load, is_tick, issue, hit, scan_end, out_free, wr_en;
    logic [2*CW-1:0] rd_data;
    logic [SQW:0] d2;
    logic signed [DW-1:0] rd_dx, rd_dy;
    logic signed [lsc_pkg::ZW-1:0] z_rnd;
    logic signed [PW:0] ang_full;
    logic signed [AVW-1:0] ang_sat;
    lsc_pkg::t_cordic_req cq;
    lsc_pkg::t_cordic_rsp cr;

    assign i_in.ready = (r_state == lsc_pkg::S_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign is_load    = in_acc && (i_in.command == lsc_pkg::CMD_LOAD);
    assign is_tick    = in_acc && (i_in.command == lsc_pkg::CMD_TICK);
    assign wr_en      = is_load && (r_load_idx < LW'(MAX_WAYPOINTS));

    lsc_ram #(.WIDTH(2 * CW), .DEPTH(MAX_WAYPOINTS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_load_idx[AW-1:0]),
        .i_wdata ({i_in.point_x, i_in.point_y}),
        .i_raddr (r_k[AW-1:0]),
        .o_rdata (rd_data)
    );

    assign issue    = (r_state == lsc_pkg::S_SCAN) && (r_k < r_len);
    assign rd_dx    = DW'($signed(rd_data[2*CW-1:CW])) - DW'(r_px);
    assign rd_dy    = DW'($signed(rd_data[CW-1:0])) - DW'(r_py);
    assign d2       = {1'b0, r_sqx} + {1'b0, r_sqy};
    assign hit      = r_v3 && (d2 >= (SQW+1)'(r_la2));
    assign scan_end = (r_state == lsc_pkg::S_SCAN)
                   && (hit || (!issue && !r_v1 && !r_v2 && !r_v3));

    assign cq.start = (r_state == lsc_pkg::S_CSTART);
    assign cq.dx    = DW'(r_tx) - DW'(r_px);
    assign cq.dy    = DW'(r_ty) - DW'(r_py);

    lsc_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (cq),
        .o_rsp   (cr)
    );

    assign z_rnd    = cr.z + lsc_pkg::ZW'(2048);
    assign out_free = !r_ovalid || o_out.ready;
    assign ang_full = (PW+1)'(r_prod) + (PW+1)'(128);

    always_comb begin
        if ((ang_full >>> 8) > (PW+1)'(lsc_pkg::ANG_MAX)) begin
            ang_sat = lsc_pkg::ANG_MAX;
        end else if ((ang_full >>> 8) < (PW+1)'(lsc_pkg::ANG_MIN)) begin
            ang_sat = lsc_pkg::ANG_MIN;
        end else begin
            ang_sat = AVW'(ang_full >>> 8);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            lsc_pkg::S_IDLE:   if (is_tick && r_len != '0) n_state = lsc_pkg::S_SCAN;
            lsc_pkg::S_SCAN:   if (scan_end) n_state = lsc_pkg::S_CSTART;
            lsc_pkg::S_CSTART: n_state = lsc_pkg::S_CWAIT;
            lsc_pkg::S_CWAIT:  if (cr.done) n_state = lsc_pkg::S_ERR;
            lsc_pkg::S_ERR:    n_state = lsc_pkg::S_MUL;
            lsc_pkg::S_MUL:    n_state = lsc_pkg::S_RES;
            lsc_pkg::S_RES:    if (out_free) n_state = lsc_pkg::S_IDLE;
            default:           n_state = lsc_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= lsc_pkg::S_IDLE;
            r_look     <= 16'd512;
            r_speed    <= 16'd512;
            r_gain     <= 12'd512;
            r_len      <= '0;
            r_load_idx <= '0;
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            r_v3       <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    lsc_pkg::CFG_LOOKAHEAD: r_look  <= i_cfg_data;
                    lsc_pkg::CFG_SPEED:     r_speed <= i_cfg_data;
                    lsc_pkg::CFG_GAIN:      r_gain  <= i_cfg_data[11:0];
                    default: ;
                endcase
            end
            if (is_load) begin
                if (i_in.path_end) begin
                    r_len      <= wr_en ? r_load_idx + LW'(1) : r_load_idx;
                    r_load_idx <= '0;
                end else begin
                    r_len <= '0;
                    if (wr_en) r_load_idx <= r_load_idx + LW'(1);
                end
            end
            if (r_state == lsc_pkg::S_SCAN && !scan_end) begin
                r_v1 <= issue;
                r_v2 <= r_v1;
                r_v3 <= r_v2;
            end else begin
                r_v1 <= 1'b0;
                r_v2 <= 1'b0;
                r_v3 <= 1'b0;
            end
            if (r_state == lsc_pkg::S_RES && out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end

        if (is_tick) begin
            r_px   <= i_in.point_x;
            r_py   <= i_in.point_y;
            r_head <= i_in.robot_heading;
            r_la2  <= r_look * r_look;
            r_k    <= '0;
        end else if (issue) begin
            r_k <= r_k + LW'(1);
        end
        r_dx  <= rd_dx;
        r_dy  <= rd_dy;
        r_wx2 <= $signed(rd_data[2*CW-1:CW]);
        r_wy2 <= $signed(rd_data[CW-1:0]);
        r_sqx <= r_dx * r_dx;
        r_sqy <= r_dy * r_dy;
        r_wx3 <= r_wx2;
        r_wy3 <= r_wy2;
        if (scan_end) begin
            r_found <= hit;
            r_tx    <= hit ? r_wx3 : '0;
            r_ty    <= hit ? r_wy3 : '0;
        end
        if (cr.done) r_bear <= BW'(z_rnd >>> 12);
        if (r_state == lsc_pkg::S_ERR) r_err <= EW'(r_bear) - EW'(r_head);
        if (r_state == lsc_pkg::S_MUL) r_prod <= $signed({1'b0, r_gain}) * r_err;
        if (r_state == lsc_pkg::S_RES && out_free) begin
            r_olin   <= r_speed;
            r_oang   <= ang_sat;
            r_ofound <= r_found;
        end
    end

    assign o_out.valid            = r_ovalid;
    assign o_out.linear_velocity  = r_olin;
    assign o_out.angular_velocity = r_oang;
    assign o_out.target_found     = r_ofound;
endmodule

/* hdl/lsc_chk.sv */
// ---------------------------------------------------------------------------
// lsc_chk
// Port-level checks of the lookahead steering controller.
// ---------------------------------------------------------------------------
module lsc_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        in_command,
    input logic        out_valid,
    input logic        out_ready,
    input logic [22:0] out_ang
);
    a_rst_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !out_valid)
        else $error("output word valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_ang))
        else $error("stalled output word changed");

    a_load_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready && in_command == lsc_pkg::CMD_LOAD |=> in_ready)
        else $error("load word blocked input");

    a_res_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared while idle");
endmodule

bind lookahead_steering_controller_unit lsc_chk u_lsc_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .in_valid   (i_in.valid),
    .in_ready   (i_in.ready),
    .in_command (i_in.command),
    .out_valid  (o_out.valid),
    .out_ready  (o_out.ready),
    .out_ang    (o_out.angular_velocity)
);
